[rtl/core/lobm_pkg.sv]
package lobm_pkg;

  localparam int PRICE_LEVELS = 256;
  localparam int LEVEL_DEPTH  = 16;
  localparam int PRICE_W      = 8;
  localparam int AMT_W        = 32;
  localparam int TRADER_W     = 32;
  localparam int ID_W         = 64;
  localparam int LVL_W        = $clog2(PRICE_LEVELS);
  localparam int POS_W        = $clog2(LEVEL_DEPTH);
  localparam int CNT_W        = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOT_W       = LVL_W + POS_W;
  localparam int SLOT_COUNT   = PRICE_LEVELS * LEVEL_DEPTH;
  localparam int GRP_SIZE     = 16;
  localparam int GRP_W        = $clog2(GRP_SIZE);
  localparam int GRP_COUNT    = PRICE_LEVELS / GRP_SIZE;

  typedef enum logic [1:0] {
    OP_ADD_BID = 2'd0,
    OP_ADD_ASK = 2'd1,
    OP_QUERY   = 2'd2,
    OP_SPARE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LVL,
    S_PUSH,
    S_GRP,
    S_BIT,
    S_DEC,
    S_MLVL,
    S_MAMT,
    S_TRADE,
    S_RLVL,
    S_RAMT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] head;
    logic [CNT_W-1:0] count;
  } level_t;

  // Highest set bit of a group word.
  function automatic logic [GRP_W-1:0] hi_idx(input logic [GRP_SIZE-1:0] v);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int i = 0; i < GRP_SIZE; i++) begin
      if (v[i]) r = GRP_W'(i);
    end
    return r;
  endfunction

  // Lowest set bit of a group word.
  function automatic logic [GRP_W-1:0] lo_idx(input logic [GRP_SIZE-1:0] v);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) r = GRP_W'(i);
    end
    return r;
  endfunction

endpackage

[rtl/core/limit_order_book_matcher_core.sv]
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------
// request   | req_valid / req_stall   | opcode, trader_id, order_amount,
//           |                         | limit_price
// response  | rsp_valid / rsp_stall   | assigned_id, rejected, best_bid_price,
//           |                         | worst_bid_price, best_ask_price,
//           |                         | bids_at_price, asks_at_price, top_ask_amount
//
// A request runs through level read, push, best-price search, decision, level
// read, amount read and output; each trade step of a bid adds a level read, an
// amount read and the trade before the search repeats. The search (group, then
// level, over a 16x16 occupancy map) and one read port per memory set this order.
// Reset is synchronous: the occupancy map, sequence counter, response valid and
// sequencer clear, so no clearing pass is needed; level and slot memories stay unset.
// req_stall stays high while a request is in work; a held response does not
// block acceptance of the next request, only its final write to the outputs.
module limit_order_book_matcher_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [1:0]                     opcode,
  input  logic [lobm_pkg::TRADER_W-1:0]  trader_id,
  input  logic [lobm_pkg::AMT_W-1:0]     order_amount,
  input  logic [lobm_pkg::PRICE_W-1:0]   limit_price,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [lobm_pkg::ID_W-1:0]      assigned_id,
  output logic                           rejected,
  output logic [lobm_pkg::PRICE_W-1:0]   best_bid_price,
  output logic [lobm_pkg::PRICE_W-1:0]   worst_bid_price,
  output logic [lobm_pkg::PRICE_W-1:0]   best_ask_price,
  output logic [lobm_pkg::CNT_W-1:0]     bids_at_price,
  output logic [lobm_pkg::CNT_W-1:0]     asks_at_price,
  output logic [lobm_pkg::AMT_W-1:0]     top_ask_amount
);
  import lobm_pkg::*;

  state_t state, state_next;

  // Latched request.
  opcode_t             op_q;
  logic [TRADER_W-1:0] trader_q;
  logic [AMT_W-1:0]    amt_q;
  logic [PRICE_W-1:0]  price_q;

  logic [ID_W-1:0]     seq, id_q;
  logic                rej_q;

  // One occupancy bit per level and side; a clear bit means count zero.
  logic [PRICE_LEVELS-1:0] bid_occ, bid_occ_next, ask_occ, ask_occ_next;

  // Level memories: ring head and count per price.
  level_t bid_lvl_mem [PRICE_LEVELS];
  level_t ask_lvl_mem [PRICE_LEVELS];
  level_t bid_lvl_q, ask_lvl_q, bid_lvl, ask_lvl;
  logic   bid_occ_q, ask_occ_q;
  logic   lvl_re;
  logic [LVL_W-1:0] bid_lvl_raddr, ask_lvl_raddr;
  logic   bid_lvl_we, ask_lvl_we;
  logic [LVL_W-1:0] bid_lvl_waddr, ask_lvl_waddr;
  level_t bid_lvl_wdata, ask_lvl_wdata;

  // Slot memories: amount and owner per order slot.
  logic [AMT_W-1:0]    bid_amt_mem [SLOT_COUNT];
  logic [AMT_W-1:0]    ask_amt_mem [SLOT_COUNT];
  logic [TRADER_W-1:0] bid_trd_mem [SLOT_COUNT];
  logic [TRADER_W-1:0] ask_trd_mem [SLOT_COUNT];
  logic [AMT_W-1:0]    bid_amt_q, ask_amt_q;
  logic                bid_amt_re, ask_amt_re;
  logic [SLOT_W-1:0]   bid_amt_raddr, ask_amt_raddr;
  logic                bid_amt_we, ask_amt_we, trd_we;
  logic [SLOT_W-1:0]   bid_amt_waddr, ask_amt_waddr;
  logic [AMT_W-1:0]    bid_amt_wdata, ask_amt_wdata;

  // Best-price search results.
  logic [GRP_COUNT-1:0] bid_grp, ask_grp;
  logic [GRP_W-1:0]     bh_g, bl_g, al_g;
  logic                 bid_any, ask_any;
  logic [LVL_W-1:0]     hb, wb, la;

  // Push and trade helpers.
  level_t              push_lvl;
  logic                push_full;
  logic [POS_W-1:0]    push_pos;
  logic [AMT_W-1:0]    trade;
  logic                bid_pop, ask_pop;
  logic                seq_inc;
  logic                rsp_load;

  // Unoccupied levels read as head zero, count zero.
  assign bid_lvl  = bid_occ_q ? bid_lvl_q : '0;
  assign ask_lvl  = ask_occ_q ? ask_lvl_q : '0;
  assign push_lvl = (op_q == OP_ADD_BID) ? bid_lvl : ask_lvl;
  assign push_full = push_lvl.count >= CNT_W'(LEVEL_DEPTH);
  assign push_pos  = push_lvl.head + push_lvl.count[POS_W-1:0];

  assign trade   = (bid_amt_q < ask_amt_q) ? bid_amt_q : ask_amt_q;
  assign bid_pop = bid_amt_q <= ask_amt_q;
  assign ask_pop = ask_amt_q <= bid_amt_q;

  assign req_stall = state != S_IDLE;
  assign rsp_load  = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      bid_grp[g] = |bid_occ[g*GRP_SIZE +: GRP_SIZE];
      ask_grp[g] = |ask_occ[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    lvl_re        = 1'b0;
    bid_lvl_raddr = price_q;
    ask_lvl_raddr = price_q;
    bid_lvl_we    = 1'b0;
    ask_lvl_we    = 1'b0;
    bid_lvl_waddr = price_q;
    ask_lvl_waddr = price_q;
    bid_lvl_wdata = '0;
    ask_lvl_wdata = '0;
    bid_amt_re    = 1'b0;
    ask_amt_re    = 1'b0;
    bid_amt_raddr = {hb, bid_lvl.head};
    ask_amt_raddr = {la, ask_lvl.head};
    bid_amt_we    = 1'b0;
    ask_amt_we    = 1'b0;
    trd_we        = 1'b0;
    bid_amt_waddr = {price_q, push_pos};
    ask_amt_waddr = {price_q, push_pos};
    bid_amt_wdata = amt_q;
    ask_amt_wdata = amt_q;
    bid_occ_next  = bid_occ;
    ask_occ_next  = ask_occ;
    seq_inc       = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_LVL;
      end
      S_LVL: begin
        lvl_re     = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // Queue the order at the back of its level ring unless full.
        if ((op_q == OP_ADD_BID || op_q == OP_ADD_ASK) && !push_full) begin
          seq_inc = 1'b1;
          trd_we  = 1'b1;
          if (op_q == OP_ADD_BID) begin
            bid_amt_we            = 1'b1;
            bid_lvl_we            = 1'b1;
            bid_lvl_wdata.head    = push_lvl.head;
            bid_lvl_wdata.count   = push_lvl.count + 1'b1;
            bid_occ_next[price_q] = 1'b1;
          end else begin
            ask_amt_we            = 1'b1;
            ask_lvl_we            = 1'b1;
            ask_lvl_wdata.head    = push_lvl.head;
            ask_lvl_wdata.count   = push_lvl.count + 1'b1;
            ask_occ_next[price_q] = 1'b1;
          end
        end
        state_next = S_GRP;
      end
      S_GRP: state_next = S_BIT;
      S_BIT: state_next = S_DEC;
      S_DEC: begin
        if (op_q == OP_ADD_BID && bid_any && ask_any && hb >= la) begin
          state_next = S_MLVL;
        end else begin
          state_next = S_RLVL;
        end
      end
      S_MLVL: begin
        lvl_re        = 1'b1;
        bid_lvl_raddr = hb;
        ask_lvl_raddr = la;
        state_next    = S_MAMT;
      end
      S_MAMT: begin
        bid_amt_re = 1'b1;
        ask_amt_re = 1'b1;
        state_next = S_TRADE;
      end
      S_TRADE: begin
        // Trade the smaller amount and drop emptied fronts.
        bid_amt_we    = 1'b1;
        ask_amt_we    = 1'b1;
        bid_amt_waddr = {hb, bid_lvl.head};
        ask_amt_waddr = {la, ask_lvl.head};
        bid_amt_wdata = bid_amt_q - trade;
        ask_amt_wdata = ask_amt_q - trade;
        bid_lvl_waddr = hb;
        ask_lvl_waddr = la;
        bid_lvl_wdata.head  = bid_lvl.head + 1'b1;
        bid_lvl_wdata.count = bid_lvl.count - 1'b1;
        ask_lvl_wdata.head  = ask_lvl.head + 1'b1;
        ask_lvl_wdata.count = ask_lvl.count - 1'b1;
        if (bid_pop) begin
          bid_lvl_we = 1'b1;
          if (bid_lvl.count == CNT_W'(1)) bid_occ_next[hb] = 1'b0;
        end
        if (ask_pop) begin
          ask_lvl_we = 1'b1;
          if (ask_lvl.count == CNT_W'(1)) ask_occ_next[la] = 1'b0;
        end
        state_next = S_GRP;
      end
      S_RLVL: begin
        lvl_re     = 1'b1;
        state_next = S_RAMT;
      end
      S_RAMT: begin
        ask_amt_re    = 1'b1;
        ask_amt_raddr = {price_q, ask_lvl.head};
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (bid_lvl_we) bid_lvl_mem[bid_lvl_waddr] <= bid_lvl_wdata;
    if (ask_lvl_we) ask_lvl_mem[ask_lvl_waddr] <= ask_lvl_wdata;
    if (lvl_re) begin
      bid_lvl_q <= bid_lvl_mem[bid_lvl_raddr];
      ask_lvl_q <= ask_lvl_mem[ask_lvl_raddr];
      bid_occ_q <= bid_occ[bid_lvl_raddr];
      ask_occ_q <= ask_occ[ask_lvl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bid_amt_we) bid_amt_mem[bid_amt_waddr] <= bid_amt_wdata;
    if (bid_amt_re) bid_amt_q <= bid_amt_mem[bid_amt_raddr];
    if (trd_we && op_q == OP_ADD_BID) bid_trd_mem[bid_amt_waddr] <= trader_q;
  end

  always_ff @(posedge clk) begin
    if (ask_amt_we) ask_amt_mem[ask_amt_waddr] <= ask_amt_wdata;
    if (ask_amt_re) ask_amt_q <= ask_amt_mem[ask_amt_raddr];
    if (trd_we && op_q == OP_ADD_ASK) ask_trd_mem[ask_amt_waddr] <= trader_q;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_occ   <= '0;
      ask_occ   <= '0;
      seq       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      bid_occ <= bid_occ_next;
      ask_occ <= ask_occ_next;
      if (seq_inc) seq <= seq + 1'b1;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op_q     <= opcode_t'(opcode);
      trader_q <= trader_id;
      amt_q    <= order_amount;
      price_q  <= limit_price;
    end
    if (state == S_PUSH) begin
      if ((op_q == OP_ADD_BID || op_q == OP_ADD_ASK) && !push_full) begin
        id_q  <= seq + 1'b1;
        rej_q <= 1'b0;
      end else begin
        id_q  <= '0;
        rej_q <= op_q == OP_ADD_BID || op_q == OP_ADD_ASK;
      end
    end
    // Search, coarse step: pick the group.
    if (state == S_GRP) begin
      bh_g    <= hi_idx(bid_grp);
      bl_g    <= lo_idx(bid_grp);
      al_g    <= lo_idx(ask_grp);
      bid_any <= |bid_grp;
      ask_any <= |ask_grp;
    end
    // Search, fine step: pick the level inside the group.
    if (state == S_BIT) begin
      hb <= {bh_g, hi_idx(bid_occ[int'(bh_g)*GRP_SIZE +: GRP_SIZE])};
      wb <= {bl_g, lo_idx(bid_occ[int'(bl_g)*GRP_SIZE +: GRP_SIZE])};
      la <= {al_g, lo_idx(ask_occ[int'(al_g)*GRP_SIZE +: GRP_SIZE])};
    end
    if (rsp_load) begin
      assigned_id     <= id_q;
      rejected        <= rej_q;
      best_bid_price  <= bid_any ? PRICE_W'(hb) : '0;
      worst_bid_price <= bid_any ? PRICE_W'(wb) : '0;
      best_ask_price  <= ask_any ? PRICE_W'(la) : '0;
      bids_at_price   <= bid_lvl.count;
      asks_at_price   <= ask_lvl.count;
      top_ask_amount  <= ask_occ_q ? ask_amt_q : '0;
    end
  end

endmodule

[rtl/core/lobm_checker.sv]
module lobm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [lobm_pkg::ID_W-1:0]     assigned_id,
  input logic                          rejected,
  input logic [lobm_pkg::PRICE_W-1:0]  best_bid_price,
  input logic [lobm_pkg::PRICE_W-1:0]  worst_bid_price,
  input logic [lobm_pkg::CNT_W-1:0]    bids_at_price,
  input logic [lobm_pkg::CNT_W-1:0]    asks_at_price
);
  import lobm_pkg::*;

  // A request occupies the block: no second request the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  a_rej_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rejected |-> assigned_id == '0)
    else $error("rejected order got a number");

  a_bid_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> worst_bid_price <= best_bid_price)
    else $error("worst bid above best bid");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> bids_at_price <= CNT_W'(LEVEL_DEPTH)
                  && asks_at_price <= CNT_W'(LEVEL_DEPTH))
    else $error("queue count beyond depth");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(assigned_id))
    else $error("stalled response changed");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (.*);

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  // One request as the driver presents it.
  typedef struct {
    logic [1:0]          op;
    logic [TRADER_W-1:0] trader;
    logic [AMT_W-1:0]    amt;
    logic [PRICE_W-1:0]  price;
  } order_req_t;

  // One book snapshot as the block reports it.
  typedef struct {
    logic [ID_W-1:0]    id;
    logic               rej;
    logic [PRICE_W-1:0] bb;
    logic [PRICE_W-1:0] wb;
    logic [PRICE_W-1:0] ba;
    logic [CNT_W-1:0]   nb;
    logic [CNT_W-1:0]   na;
    logic [AMT_W-1:0]   top;
  } book_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] opcode = '0;
  logic [TRADER_W-1:0] trader_id = '0;
  logic [AMT_W-1:0] order_amount = '0;
  logic [PRICE_W-1:0] limit_price = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [ID_W-1:0] assigned_id;
  logic rejected;
  logic [PRICE_W-1:0] best_bid_price, worst_bid_price, best_ask_price;
  logic [CNT_W-1:0] bids_at_price, asks_at_price;
  logic [AMT_W-1:0] top_ask_amount;

  limit_order_book_matcher_core dut (
    .clk, .rst, .req_valid, .req_stall, .opcode, .trader_id, .order_amount,
    .limit_price, .rsp_valid, .rsp_stall, .assigned_id, .rejected,
    .best_bid_price, .worst_bid_price, .best_ask_price, .bids_at_price,
    .asks_at_price, .top_ask_amount
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow book: amounts per slot, ring head and depth per price and side.
  logic [AMT_W-1:0] bid_amt [SLOT_COUNT];
  logic [AMT_W-1:0] ask_amt [SLOT_COUNT];
  int unsigned bid_head [PRICE_LEVELS];
  int unsigned bid_cnt [PRICE_LEVELS];
  int unsigned ask_head [PRICE_LEVELS];
  int unsigned ask_cnt [PRICE_LEVELS];
  logic [ID_W-1:0] seq_no;

  order_req_t pending_reqs[$];
  book_rsp_t  expected_snaps[$];
  int mismatches = 0;
  longint cycle = 0;
  bit quiet = 0;       // stretch with no idling on either side
  bit hold_rsp = 0;    // long receiver hold-off
  bit stim_done = 0;

  function automatic int hi_level(ref int unsigned cnt[PRICE_LEVELS]);
    for (int i = PRICE_LEVELS - 1; i >= 0; i--) if (cnt[i] > 0) return i;
    return -1;
  endfunction

  function automatic int lo_level(ref int unsigned cnt[PRICE_LEVELS]);
    for (int i = 0; i < PRICE_LEVELS; i++) if (cnt[i] > 0) return i;
    return -1;
  endfunction

  // Apply one request to the shadow book and return the expected snapshot.
  function automatic book_rsp_t apply_order(order_req_t r);
    book_rsp_t s;
    int p, hb, la, bs, as;
    logic [AMT_W-1:0] tr;
    s = '{default: '0};
    p = r.price;
    if (r.op == OP_ADD_BID || r.op == OP_ADD_ASK) begin
      if (r.op == OP_ADD_BID) begin
        if (bid_cnt[p] >= LEVEL_DEPTH) s.rej = 1;
        else begin
          seq_no++;
          bid_amt[p*LEVEL_DEPTH + (bid_head[p] + bid_cnt[p]) % LEVEL_DEPTH] = r.amt;
          bid_cnt[p]++;
          s.id = seq_no;
        end
        // Match while the book is crossed, even after a reject.
        forever begin
          hb = hi_level(bid_cnt);
          la = lo_level(ask_cnt);
          if (hb < 0 || la < 0 || hb < la) break;
          bs = hb*LEVEL_DEPTH + bid_head[hb];
          as = la*LEVEL_DEPTH + ask_head[la];
          tr = (bid_amt[bs] < ask_amt[as]) ? bid_amt[bs] : ask_amt[as];
          bid_amt[bs] -= tr;
          ask_amt[as] -= tr;
          if (bid_amt[bs] == 0) begin
            bid_head[hb] = (bid_head[hb] + 1) % LEVEL_DEPTH;
            bid_cnt[hb]--;
          end
          if (ask_amt[as] == 0) begin
            ask_head[la] = (ask_head[la] + 1) % LEVEL_DEPTH;
            ask_cnt[la]--;
          end
        end
      end else begin
        if (ask_cnt[p] >= LEVEL_DEPTH) s.rej = 1;
        else begin
          seq_no++;
          ask_amt[p*LEVEL_DEPTH + (ask_head[p] + ask_cnt[p]) % LEVEL_DEPTH] = r.amt;
          ask_cnt[p]++;
          s.id = seq_no;
        end
      end
    end
    hb = hi_level(bid_cnt);
    if (hb >= 0) s.bb = PRICE_W'(hb);
    hb = lo_level(bid_cnt);
    if (hb >= 0) s.wb = PRICE_W'(hb);
    la = lo_level(ask_cnt);
    if (la >= 0) s.ba = PRICE_W'(la);
    s.nb = CNT_W'(bid_cnt[p]);
    s.na = CNT_W'(ask_cnt[p]);
    if (ask_cnt[p] > 0) s.top = ask_amt[p*LEVEL_DEPTH + ask_head[p]];
    return s;
  endfunction

  function automatic order_req_t mk(logic [1:0] op, logic [31:0] tr, logic [31:0] a,
                                    logic [7:0] p);
    order_req_t r;
    r.op = op; r.trader = tr; r.amt = a; r.price = p;
    return r;
  endfunction

  // Append one request to the driver's queue.
  function automatic void queue_req(order_req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Narrow price band so that levels fill, cross and empty often.
  function automatic logic [PRICE_W-1:0] band_price();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return PRICE_W'($urandom_range(0, 255));
    if (k == 1) return 8'd0;
    if (k == 2) return 8'd255;
    return PRICE_W'($urandom_range(120, 135));
  endfunction

  function automatic logic [AMT_W-1:0] rand_amt();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return AMT_W'($urandom);
      default: return AMT_W'($urandom_range(1, 100));
    endcase
  endfunction

  // Driver: advance to the next request once the current one is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 35)) begin
          order_req_t r;
          r = pending_reqs.pop_front();
          expected_snaps = {expected_snaps, apply_order(r)};
          req_valid <= 1'b1;
          opcode <= r.op;
          trader_id <= r.trader;
          order_amount <= r.amt;
          limit_price <= r.price;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken response with the oldest snapshot.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      rsp_stall <= hold_rsp || (!quiet && $urandom_range(0, 99) < 35);
      if (rsp_valid && !rsp_stall) begin
        if (expected_snaps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response id=%0d", assigned_id);
        end else begin
          book_rsp_t e;
          e = expected_snaps.pop_front();
          if (e.id !== assigned_id || e.rej !== rejected || e.bb !== best_bid_price ||
              e.wb !== worst_bid_price || e.ba !== best_ask_price ||
              e.nb !== bids_at_price || e.na !== asks_at_price ||
              e.top !== top_ask_amount) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp id=%0d rej=%0d bb=%0d wb=%0d ba=%0d nb=%0d na=%0d top=%0d",
                       e.id, e.rej, e.bb, e.wb, e.ba, e.nb, e.na, e.top,
                       "\n         got id=%0d rej=%0d bb=%0d wb=%0d ba=%0d nb=%0d na=%0d top=%0d",
                       assigned_id, rejected, best_bid_price, worst_bid_price,
                       best_ask_price, bids_at_price, asks_at_price, top_ask_amount);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    int n;
    wait (!rst);
    repeat (1500) @(posedge clk);
    hold_rsp = 1;
    n = 0;
    while (n < 300) begin
      @(posedge clk);
      n++;
    end
    hold_rsp = 0;
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    order_req_t r;
    for (int i = 0; i < PRICE_LEVELS; i++) begin
      bid_head[i] = 0; bid_cnt[i] = 0; ask_head[i] = 0; ask_cnt[i] = 0;
    end
    seq_no = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queries, zero prices, extreme fields, zero amount, full queue.
    queue_req(mk(OP_QUERY, '0, '0, 8'd0));
    queue_req(mk(OP_SPARE, '1, '1, 8'd255));
    queue_req(mk(OP_ADD_ASK, '1, '1, 8'd0));
    queue_req(mk(OP_QUERY, '0, '0, 8'd0));
    queue_req(mk(OP_ADD_BID, '0, 32'd5, 8'd255));
    queue_req(mk(OP_ADD_ASK, 32'h5555_5555, '0, 8'd200));
    queue_req(mk(OP_ADD_ASK, 32'hAAAA_AAAA, 32'd10, 8'd200));
    queue_req(mk(OP_ADD_BID, 32'h1, 32'd3, 8'd201));
    queue_req(mk(OP_QUERY, '0, '0, 8'd200));
    for (int i = 0; i < 17; i++)
      queue_req(mk(OP_ADD_ASK, i, 32'd7, 8'd250));
    queue_req(mk(OP_ADD_BID, '1, '1, 8'd250));
    queue_req(mk(OP_QUERY, '0, '0, 8'd250));

    // Pause the sender until the book has answered everything.
    wait (pending_reqs.size() == 0 && expected_snaps.size() == 0);

    // Random part: mostly adds in a tight band, a quiet stretch in the middle.
    for (int i = 0; i < 450; i++) begin
      int k;
      k = $urandom_range(0, 9);
      r.op = (k < 4) ? OP_ADD_BID : (k < 8) ? OP_ADD_ASK : 2'($urandom_range(2, 3));
      r.trader = TRADER_W'($urandom);
      r.amt = rand_amt();
      r.price = band_price();
      queue_req(r);
      if (i == 200) begin
        wait (pending_reqs.size() == 0);
        quiet = 1;
      end
      if (i == 280) begin
        wait (pending_reqs.size() == 0);
        quiet = 0;
      end
    end

    wait (pending_reqs.size() == 0 && expected_snaps.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_snaps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[limit_order_book_matcher_core.f]
rtl/core/lobm_pkg.sv
rtl/core/limit_order_book_matcher_core.sv
rtl/core/lobm_checker.sv
sim/tb_top.sv
